// File: rtl/rvdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants for the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  // Major opcodes (instr[6:0])
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;

  // funct3 codes that matter for legality and the alternate-op flag
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_BR_RSV2 = 3'd2;
  localparam logic [2:0] F3_BR_RSV3 = 3'd3;
  localparam logic [2:0] F3_LD_RSV3 = 3'd3;
  localparam logic [2:0] F3_LD_RSV6 = 3'd6;
  localparam logic [2:0] F3_LD_RSV7 = 3'd7;
  localparam logic [2:0] F3_ST_MAX  = 3'd2;
  localparam logic [2:0] F3_SRL_SRA = 3'd5;

  localparam logic [31:0] LINK_OFFSET = 32'd4;

  typedef enum logic [3:0] {
    CLS_LUI    = 4'd0,
    CLS_AUIPC  = 4'd1,
    CLS_JAL    = 4'd2,
    CLS_JALR   = 4'd3,
    CLS_BRANCH = 4'd4,
    CLS_LOAD   = 4'd5,
    CLS_STORE  = 4'd6,
    CLS_OPIMM  = 4'd7,
    CLS_OP     = 4'd8,
    CLS_MULDIV = 4'd9,
    CLS_FENCE  = 4'd10
  } op_class_e;

  typedef struct packed {
    op_class_e          op_class;
    logic               illegal;
    logic [4:0]         rd_index;
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic               second_is_register;
    logic [3:0]         op_detail;
    logic signed [31:0] immediate;
    logic [31:0]        target;
    logic [31:0]        result_value;
  } dec_result_t;

endpackage

// File: rtl/rvdec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_core
// Combinational decode of one instruction word and its pc.
// ----------------------------------------------------------------------------
module rvdec_core (
  input  logic [31:0]               instr_i,
  input  logic [31:0]               pc_i,
  output rvdec_pkg::dec_result_t    dec_o
);
  import rvdec_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] tgt_sum, val_sum;
  logic [31:0] tgt_addend, val_addend;
  logic        f3_bad;
  logic        known;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign alt = instr_i[30];

  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_u = {instr_i[31:12], 12'h000};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};

  // One adder for the branch/jump target, one for the write-back value
  assign tgt_addend = (opc == OPC_JAL) ? imm_j : imm_b;
  assign val_addend = (opc == OPC_AUIPC) ? imm_u : LINK_OFFSET;
  assign tgt_sum    = pc_i + tgt_addend;
  assign val_sum    = pc_i + val_addend;

  always_comb begin
    dec_o                    = '0;
    dec_o.rs1_index          = instr_i[19:15];
    dec_o.rs2_index          = instr_i[24:20];
    dec_o.rd_index           = instr_i[11:7];
    f3_bad                   = 1'b0;
    known                    = 1'b1;
    unique case (opc)
      OPC_LUI: begin
        dec_o.op_class     = CLS_LUI;
        dec_o.immediate    = imm_u;
        dec_o.result_value = imm_u;
      end
      OPC_AUIPC: begin
        dec_o.op_class     = CLS_AUIPC;
        dec_o.immediate    = imm_u;
        dec_o.result_value = val_sum;
      end
      OPC_JAL: begin
        dec_o.op_class     = CLS_JAL;
        dec_o.immediate    = imm_j;
        dec_o.target       = tgt_sum;
        dec_o.result_value = val_sum;
      end
      OPC_JALR: begin
        dec_o.op_class     = CLS_JALR;
        dec_o.immediate    = imm_i;
        dec_o.op_detail    = {1'b0, f3};
        dec_o.result_value = val_sum;
        f3_bad             = (f3 != F3_ADD_SUB);
      end
      OPC_BRANCH: begin
        dec_o.op_class           = CLS_BRANCH;
        dec_o.immediate          = imm_b;
        dec_o.op_detail          = {1'b0, f3};
        dec_o.second_is_register = 1'b1;
        dec_o.rd_index           = '0;
        dec_o.target             = tgt_sum;
        f3_bad                   = (f3 == F3_BR_RSV2) || (f3 == F3_BR_RSV3);
      end
      OPC_LOAD: begin
        dec_o.op_class  = CLS_LOAD;
        dec_o.immediate = imm_i;
        dec_o.op_detail = {1'b0, f3};
        f3_bad          = (f3 == F3_LD_RSV3) || (f3 == F3_LD_RSV6) ||
                          (f3 == F3_LD_RSV7);
      end
      OPC_STORE: begin
        dec_o.op_class           = CLS_STORE;
        dec_o.immediate          = imm_s;
        dec_o.op_detail          = {1'b0, f3};
        dec_o.second_is_register = 1'b1;
        dec_o.rd_index           = '0;
        f3_bad                   = (f3 > F3_ST_MAX);
      end
      OPC_OPIMM: begin
        dec_o.op_class  = CLS_OPIMM;
        dec_o.immediate = imm_i;
        dec_o.op_detail = {alt && (f3 == F3_SRL_SRA), f3};
      end
      OPC_OP: begin
        dec_o.second_is_register = 1'b1;
        if (instr_i[25]) begin
          dec_o.op_class  = CLS_MULDIV;
          dec_o.op_detail = {1'b0, f3};
        end else begin
          dec_o.op_class  = CLS_OP;
          dec_o.op_detail = {alt && ((f3 == F3_ADD_SUB) || (f3 == F3_SRL_SRA)), f3};
        end
      end
      OPC_FENCE: begin
        dec_o.op_class  = CLS_FENCE;
        dec_o.op_detail = {1'b0, f3};
        dec_o.rd_index  = '0;
      end
      default: begin
        known          = 1'b0;
        dec_o.rd_index = '0;
      end
    endcase

    dec_o.illegal = f3_bad || !known;
    if (f3_bad) begin
      dec_o.rd_index = '0;
      dec_o.target   = '0;
    end
  end

endmodule

// File: rtl/rv32im_instruction_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_unit
// RV32IM decoder: classifies one instruction, extracts fields and immediate,
// and forms the pc-relative target and the write-back value.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | transfer
//  ----------+---------------------------------+----------------------------
//  request   | start, busy, instr_i, pc_i      | start high, busy low
//  result    | valid_o, op_class_o .. value_o  | every cycle valid_o is high
//
// A request goes through the input stage and the result stage; valid_o is
// then high for a single cycle, and the unit takes one new instruction per
// clock. The path between the two registers is the field decode plus one
// 32-bit add (target and write-back value each have their own adder).
// busy is always low: the pipeline never holds a request off.
// Reset clears the valid flags only; the payload registers are not reset.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          instr_i,
  input  logic [31:0]          pc_i,
  output logic                 valid_o,
  output logic [3:0]           op_class_o,
  output logic                 illegal_o,
  output logic [4:0]           rd_index_o,
  output logic [4:0]           rs1_index_o,
  output logic [4:0]           rs2_index_o,
  output logic                 second_is_register_o,
  output logic [3:0]           op_detail_o,
  output logic signed [31:0]   immediate_o,
  output logic [31:0]          target_o,
  output logic [31:0]          result_value_o
);
  import rvdec_pkg::*;

  // Input stage
  logic        in_vld_q;
  logic [31:0] instr_q, pc_q;

  // Result stage
  logic        out_vld_q;
  dec_result_t res_q;
  dec_result_t res_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  // Payload only loads on a transfer / valid stage; no reset needed
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      instr_q <= instr_i;
      pc_q    <= pc_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  rvdec_core u_core (
    .instr_i (instr_q),
    .pc_i    (pc_q),
    .dec_o   (res_d)
  );

  assign valid_o              = out_vld_q;
  assign op_class_o           = res_q.op_class;
  assign illegal_o            = res_q.illegal;
  assign rd_index_o           = res_q.rd_index;
  assign rs1_index_o          = res_q.rs1_index;
  assign rs2_index_o          = res_q.rs2_index;
  assign second_is_register_o = res_q.second_is_register;
  assign op_detail_o          = res_q.op_detail;
  assign immediate_o          = res_q.immediate;
  assign target_o             = res_q.target;
  assign result_value_o       = res_q.result_value;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv32im_instruction_decoder_unit: every accepted
// instruction is decoded by a local model, each result strobe is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import rvdec_pkg::*;

  // funct3 values that the package does not name
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_LBU    = 3'd4;
  localparam logic [2:0] F3_ST_RSV = 3'd5;
  localparam logic [2:0] F3_BGEU   = 3'd7;

  localparam int unsigned RANDOM_COUNT = 600;
  localparam int unsigned DRAIN_LIMIT  = 200;

  // --------------------------------------------------------------------------
  // Scoreboard: decodes each accepted instruction into the expected result and
  // holds those results in arrival order until the matching strobe shows up.
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    dec_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Local decode of one instruction word at one pc.
    function dec_result_t decode_instruction(logic [31:0] word, logic [31:0] addr);
      dec_result_t r;
      logic [2:0]  f3;
      logic        alt;
      logic [31:0] imm_i, imm_u, imm_s, imm_b, imm_j;
      f3    = word[14:12];
      alt   = word[30];
      imm_i = {{20{word[31]}}, word[31:20]};
      imm_u = {word[31:12], 12'b0};
      imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
      imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
      r = '0;
      r.op_class  = CLS_LUI;
      r.rd_index  = word[11:7];
      r.rs1_index = word[19:15];
      r.rs2_index = word[24:20];
      case (word[6:0])
        OPC_LUI: begin
          r.immediate    = imm_u;
          r.result_value = imm_u;
        end
        OPC_AUIPC: begin
          r.op_class     = CLS_AUIPC;
          r.immediate    = imm_u;
          r.result_value = addr + imm_u;
        end
        OPC_JAL: begin
          r.op_class     = CLS_JAL;
          r.immediate    = imm_j;
          r.target       = addr + imm_j;
          r.result_value = addr + LINK_OFFSET;
        end
        OPC_JALR: begin
          r.op_class     = CLS_JALR;
          r.immediate    = imm_i;
          r.op_detail    = {1'b0, f3};
          r.result_value = addr + LINK_OFFSET;
          r.illegal      = (f3 != F3_ADD_SUB);
        end
        OPC_BRANCH: begin
          r.op_class           = CLS_BRANCH;
          r.immediate          = imm_b;
          r.op_detail          = {1'b0, f3};
          r.second_is_register = 1'b1;
          r.rd_index           = '0;
          r.illegal            = (f3 == F3_BR_RSV2) || (f3 == F3_BR_RSV3);
          r.target             = addr + imm_b;
        end
        OPC_LOAD: begin
          r.op_class  = CLS_LOAD;
          r.immediate = imm_i;
          r.op_detail = {1'b0, f3};
          r.illegal   = (f3 == F3_LD_RSV3) || (f3 == F3_LD_RSV6) || (f3 == F3_LD_RSV7);
        end
        OPC_STORE: begin
          r.op_class           = CLS_STORE;
          r.immediate          = imm_s;
          r.op_detail          = {1'b0, f3};
          r.second_is_register = 1'b1;
          r.rd_index           = '0;
          r.illegal            = (f3 > F3_ST_MAX);
        end
        OPC_OPIMM: begin
          r.op_class  = CLS_OPIMM;
          r.immediate = imm_i;
          r.op_detail = {(f3 == F3_SRL_SRA) && alt, f3};
        end
        OPC_OP: begin
          r.second_is_register = 1'b1;
          r.op_detail          = {1'b0, f3};
          if (word[25]) begin
            r.op_class = CLS_MULDIV;
          end else begin
            r.op_class  = CLS_OP;
            r.op_detail = {((f3 == F3_ADD_SUB) || (f3 == F3_SRL_SRA)) && alt, f3};
          end
        end
        OPC_FENCE: begin
          r.op_class  = CLS_FENCE;
          r.op_detail = {1'b0, f3};
          r.rd_index  = '0;
        end
        default: begin
          r.illegal  = 1'b1;
          r.rd_index = '0;
        end
      endcase
      if (r.illegal) begin
        r.rd_index = '0;
        r.target   = '0;
      end
      return r;
    endfunction

    function void note_instruction(logic [31:0] word, logic [31:0] addr);
      expected_q.push_back(decode_instruction(word, addr));
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
        $error("%s: expected %h, actual %h", name, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_result(dec_result_t actual);
      dec_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result strobe with no instruction outstanding");
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("op_class", 32'(exp_r.op_class), 32'(actual.op_class));
      compare_field("illegal", 32'(exp_r.illegal), 32'(actual.illegal));
      compare_field("rd_index", 32'(exp_r.rd_index), 32'(actual.rd_index));
      compare_field("rs1_index", 32'(exp_r.rs1_index), 32'(actual.rs1_index));
      compare_field("rs2_index", 32'(exp_r.rs2_index), 32'(actual.rs2_index));
      compare_field("second_is_register", 32'(exp_r.second_is_register),
                    32'(actual.second_is_register));
      compare_field("op_detail", 32'(exp_r.op_detail), 32'(actual.op_detail));
      compare_field("immediate", exp_r.immediate, actual.immediate);
      compare_field("target", exp_r.target, actual.target);
      compare_field("result_value", exp_r.result_value, actual.result_value);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic [31:0]        instr_i = '0;
  logic [31:0]        pc_i    = '0;
  logic               busy;
  logic               valid_o;
  logic [3:0]         op_class_o;
  logic               illegal_o;
  logic [4:0]         rd_index_o;
  logic [4:0]         rs1_index_o;
  logic [4:0]         rs2_index_o;
  logic               second_is_register_o;
  logic [3:0]         op_detail_o;
  logic signed [31:0] immediate_o;
  logic [31:0]        target_o;
  logic [31:0]        result_value_o;

  rv32im_instruction_decoder_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .instr_i              (instr_i),
    .pc_i                 (pc_i),
    .valid_o              (valid_o),
    .op_class_o           (op_class_o),
    .illegal_o            (illegal_o),
    .rd_index_o           (rd_index_o),
    .rs1_index_o          (rs1_index_o),
    .rs2_index_o          (rs2_index_o),
    .second_is_register_o (second_is_register_o),
    .op_detail_o          (op_detail_o),
    .immediate_o          (immediate_o),
    .target_o             (target_o),
    .result_value_o       (result_value_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  decode_scoreboard decode_sb = new();

  // Result ports packed into the package struct for a single compare call.
  dec_result_t observed;
  assign observed = {op_class_o, illegal_o, rd_index_o, rs1_index_o, rs2_index_o,
                     second_is_register_o, op_detail_o, immediate_o, target_o,
                     result_value_o};

  // --------------------------------------------------------------------------
  // Monitor. Sampled in the active region of the rising edge, so it sees the
  // pre-edge values of both the bench (NBA driven) and the DUT registers.
  // A request transfer is start high with busy low; a result transfer is any
  // cycle with valid_o high, since the receiver has no way to stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        decode_sb.note_instruction(instr_i, pc_i);
      end
      if (valid_o) begin
        decode_sb.check_result(observed);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Present one instruction and hold it until the transfer. busy only moves
  // on a rising edge, so its value at the falling edge is the one the next
  // rising edge will see.
  task automatic issue_instruction(input logic [31:0] word, input logic [31:0] addr);
    start   <= 1'b1;
    instr_i <= word;
    pc_i    <= addr;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drop start for a gap; the payload wanders so ignored cycles carry junk.
  task automatic idle_gap(input int unsigned cycles);
    start   <= 1'b0;
    instr_i <= $urandom();
    pc_i    <= $urandom();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Mostly real opcodes with random upper bits (funct3/funct7/regs/imm),
  // the rest fully random words that mostly land on unknown opcodes.
  function automatic logic [31:0] random_instruction();
    logic [6:0]  opcodes [10];
    logic [31:0] word;
    opcodes = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD,
                OPC_STORE, OPC_OPIMM, OPC_OP, OPC_FENCE};
    word = $urandom();
    if ($urandom_range(0, 99) >= 15) begin
      word[6:0] = opcodes[$urandom_range(0, 9)];
    end
    return word;
  endfunction

  // pc near the wrap points now and then, otherwise anywhere
  function automatic logic [31:0] random_pc();
    case ($urandom_range(0, 7))
      0:       return 32'(-$urandom_range(0, 16) * 4);
      1:       return 32'($urandom_range(0, 64));
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent;
    int unsigned burst_len;
    int unsigned waited;
    sent   = 0;
    waited = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: back to back, no gaps.
    // lui with all-ones upper immediate; auipc wrapping past the top
    issue_instruction({20'hfffff, 5'd31, OPC_LUI}, 32'h0000_0000);
    issue_instruction({20'h80000, 5'd1, OPC_AUIPC}, 32'hffff_ffff);
    // jal: most negative offset from pc 0, most positive with link wrapping
    issue_instruction({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 32'h0000_0000);
    issue_instruction({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, OPC_JAL}, 32'hffff_fffc);
    // jalr legal and with a reserved funct3
    issue_instruction({12'h800, 5'd31, F3_ADD_SUB, 5'd5, OPC_JALR}, 32'h8000_0000);
    issue_instruction({12'h7ff, 5'd0, F3_SLL, 5'd7, OPC_JALR}, 32'h7fff_fffc);
    // branches: negative offset, both reserved funct3, max positive offset
    issue_instruction({1'b1, 6'h3f, 5'd2, 5'd1, F3_ADD_SUB, 4'hf, 1'b1, OPC_BRANCH},
                      32'h0000_0010);
    issue_instruction({1'b0, 6'h01, 5'd3, 5'd4, F3_BR_RSV2, 4'h2, 1'b0, OPC_BRANCH},
                      32'h0000_1000);
    issue_instruction({1'b1, 6'h20, 5'd5, 5'd6, F3_BR_RSV3, 4'h0, 1'b1, OPC_BRANCH},
                      32'h0000_2000);
    issue_instruction({1'b0, 6'h3f, 5'd31, 5'd31, F3_BGEU, 4'hf, 1'b1, OPC_BRANCH},
                      32'hffff_f000);
    // loads: the three reserved widths and one legal one
    issue_instruction({12'hfff, 5'd8, F3_LD_RSV3, 5'd9, OPC_LOAD}, 32'h0000_0100);
    issue_instruction({12'h001, 5'd8, F3_LD_RSV6, 5'd9, OPC_LOAD}, 32'h0000_0104);
    issue_instruction({12'h800, 5'd8, F3_LD_RSV7, 5'd9, OPC_LOAD}, 32'h0000_0108);
    issue_instruction({12'h7ff, 5'd10, F3_LBU, 5'd11, OPC_LOAD}, 32'h0000_010c);
    // stores: word with negative offset, reserved width
    issue_instruction({7'h7f, 5'd12, 5'd13, F3_ST_MAX, 5'h1f, OPC_STORE}, 32'h0000_0200);
    issue_instruction({7'h00, 5'd14, 5'd15, F3_ST_RSV, 5'h01, OPC_STORE}, 32'h0000_0204);
    // srai gets the alternate flag, slli with bit 30 set does not
    issue_instruction({7'h20, 5'd3, 5'd4, F3_SRL_SRA, 5'd5, OPC_OPIMM}, 32'h0000_0300);
    issue_instruction({7'h20, 5'd3, 5'd4, F3_SLL, 5'd5, OPC_OPIMM}, 32'h0000_0304);
    // register ops: sub, sra, add
    issue_instruction({7'h20, 5'd16, 5'd17, F3_ADD_SUB, 5'd18, OPC_OP}, 32'h0000_0400);
    issue_instruction({7'h20, 5'd19, 5'd20, F3_SRL_SRA, 5'd21, OPC_OP}, 32'h0000_0404);
    issue_instruction({7'h00, 5'd22, 5'd23, F3_ADD_SUB, 5'd24, OPC_OP}, 32'h0000_0408);
    // mul/div with stray funct7 bits, bit 30 must not set the alternate flag
    issue_instruction({7'h61, 5'd25, 5'd26, F3_SRL_SRA, 5'd27, OPC_OP}, 32'h0000_040c);
    // fence drops rd
    issue_instruction({4'h0, 4'hf, 4'hf, 5'd0, F3_ADD_SUB, 5'd9, OPC_FENCE},
                      32'h0000_0500);
    // unknown opcodes: all ones and all zeros
    issue_instruction(32'hffff_ffff, 32'hffff_ffff);
    issue_instruction(32'h0000_0000, 32'h0000_0000);
    idle_gap(3);

    // Random: bursts of random length, random gaps, some long gap-free runs.
    while (sent < RANDOM_COUNT) begin
      burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      repeat (burst_len) begin
        issue_instruction(random_instruction(), random_pc());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 8));
      end
    end
    idle_gap(1);

    // Drain: wait for every outstanding prediction, then keep watching a while so
    // that a stray extra strobe would still be caught.
    while (decode_sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (decode_sb.outstanding() != 0) begin
      $display("Some tests failed");
    end else begin
      repeat (6) @(posedge clk_i);
      if (decode_sb.mismatches == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #200_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
